>>> hw/rtl/fact_pkg.sv
// ----------------------------------------------------------------------------
// fact_pkg
// Types, register codes and dither tables for the fragment alpha/coverage test.
// ----------------------------------------------------------------------------
`default_nettype none

package fact_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [7:0] ALPHA_MAX     = 8'hff;
   localparam logic [3:0] ROUND_HALF    = 4'd4;
   localparam logic [1:0] DITHER_MATRIX = 2'd0;
   localparam logic [1:0] DITHER_INV    = 2'd1;
   localparam logic [1:0] DITHER_NOISE  = 2'd2;
   localparam logic [1:0] DITHER_OFF    = 2'd3;

   typedef enum logic [2:0] {
      REG_COV_TIMES_ALPHA = 3'd0,
      REG_ALPHA_FROM_COV  = 3'd1,
      REG_ANTIALIAS_ON    = 3'd2,
      REG_ALPHA_DITHER    = 3'd3,
      REG_RGB_DITHER      = 3'd4,
      REG_ALPHA_CMP_ON    = 3'd5,
      REG_CMP_USES_NOISE  = 3'd6,
      REG_BLEND_ALPHA     = 3'd7
   } fact_reg_type;

   typedef struct packed {
      logic       coverage_times_alpha;
      logic       alpha_from_coverage;
      logic       antialias_on;
      logic [1:0] alpha_dither_mode;
      logic [1:0] rgb_dither_mode;
      logic       alpha_compare_on;
      logic       compare_uses_noise;
      logic [7:0] blend_alpha;
   } fact_cfg_type;

   typedef struct packed {
      logic [7:0] color_alpha;
      logic [3:0] coverage_in;
      logic       lane_active;
      logic [1:0] x_phase;
      logic [1:0] y_phase;
      logic [7:0] pixel_noise;
   } fact_pixel_type;

   typedef struct packed {
      logic [7:0] alpha_out;
      logic [3:0] coverage_out;
      logic       accepted;
   } fact_result_type;

   // 4x4 magic square, row = y phase
   function automatic logic [2:0] magic_entry(input logic [3:0] idx);
      logic [2:0] d;
      case (idx)
         4'd0:  d = 3'd0;
         4'd1:  d = 3'd6;
         4'd2:  d = 3'd1;
         4'd3:  d = 3'd7;
         4'd4:  d = 3'd4;
         4'd5:  d = 3'd2;
         4'd6:  d = 3'd5;
         4'd7:  d = 3'd3;
         4'd8:  d = 3'd3;
         4'd9:  d = 3'd5;
         4'd10: d = 3'd2;
         4'd11: d = 3'd4;
         4'd12: d = 3'd7;
         4'd13: d = 3'd1;
         4'd14: d = 3'd6;
         4'd15: d = 3'd0;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

   function automatic logic [2:0] bayer_entry(input logic [3:0] idx);
      logic [2:0] d;
      case (idx)
         4'd0:  d = 3'd0;
         4'd1:  d = 3'd4;
         4'd2:  d = 3'd1;
         4'd3:  d = 3'd5;
         4'd4:  d = 3'd4;
         4'd5:  d = 3'd0;
         4'd6:  d = 3'd5;
         4'd7:  d = 3'd1;
         4'd8:  d = 3'd3;
         4'd9:  d = 3'd7;
         4'd10: d = 3'd2;
         4'd11: d = 3'd6;
         4'd12: d = 3'd7;
         4'd13: d = 3'd3;
         4'd14: d = 3'd6;
         4'd15: d = 3'd2;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fact_chan_if.sv
// ----------------------------------------------------------------------------
// fact_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fact_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fact_csr.sv
// ----------------------------------------------------------------------------
// fact_csr
// APB-style configuration registers of the alpha/coverage test.
// ----------------------------------------------------------------------------
`default_nettype none

module fact_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [fact_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [fact_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [fact_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output fact_pkg::fact_cfg_type                   cfg
);

   fact_pkg::fact_cfg_type cfg_ff;
   fact_pkg::fact_cfg_type cfg_in;
   fact_pkg::fact_reg_type reg_sel;
   logic                   wr_en;

   assign reg_sel    = fact_pkg::fact_reg_type'(csr_paddr[fact_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            fact_pkg::REG_COV_TIMES_ALPHA: cfg_in.coverage_times_alpha = csr_pwdata[0];
            fact_pkg::REG_ALPHA_FROM_COV:  cfg_in.alpha_from_coverage  = csr_pwdata[0];
            fact_pkg::REG_ANTIALIAS_ON:    cfg_in.antialias_on         = csr_pwdata[0];
            fact_pkg::REG_ALPHA_DITHER:    cfg_in.alpha_dither_mode    = csr_pwdata[1:0];
            fact_pkg::REG_RGB_DITHER:      cfg_in.rgb_dither_mode      = csr_pwdata[1:0];
            fact_pkg::REG_ALPHA_CMP_ON:    cfg_in.alpha_compare_on     = csr_pwdata[0];
            fact_pkg::REG_CMP_USES_NOISE:  cfg_in.compare_uses_noise   = csr_pwdata[0];
            fact_pkg::REG_BLEND_ALPHA:     cfg_in.blend_alpha          = csr_pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{alpha_dither_mode: fact_pkg::DITHER_OFF, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_sel)
         fact_pkg::REG_COV_TIMES_ALPHA: csr_prdata[0]   = cfg_ff.coverage_times_alpha;
         fact_pkg::REG_ALPHA_FROM_COV:  csr_prdata[0]   = cfg_ff.alpha_from_coverage;
         fact_pkg::REG_ANTIALIAS_ON:    csr_prdata[0]   = cfg_ff.antialias_on;
         fact_pkg::REG_ALPHA_DITHER:    csr_prdata[1:0] = cfg_ff.alpha_dither_mode;
         fact_pkg::REG_RGB_DITHER:      csr_prdata[1:0] = cfg_ff.rgb_dither_mode;
         fact_pkg::REG_ALPHA_CMP_ON:    csr_prdata[0]   = cfg_ff.alpha_compare_on;
         fact_pkg::REG_CMP_USES_NOISE:  csr_prdata[0]   = cfg_ff.compare_uses_noise;
         fact_pkg::REG_BLEND_ALPHA:     csr_prdata[7:0] = cfg_ff.blend_alpha;
         default: csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/fact_calc.sv
// ----------------------------------------------------------------------------
// fact_calc
// Coverage scaling, alpha select/dither and alpha compare for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module fact_calc (
   input  wire fact_pkg::fact_cfg_type    cfg,
   input  wire fact_pkg::fact_pixel_type  pix,
   output fact_pkg::fact_result_type      res
);

   logic [11:0] scaled_full;
   logic [8:0]  scaled;
   logic [3:0]  cov_scaled;
   logic [8:0]  alpha_base;
   logic [3:0]  cov_base;
   logic        aa_reject;
   logic [2:0]  mat_d;
   logic [2:0]  dith;
   logic [9:0]  alpha_sel;
   logic [9:0]  alpha_dith;
   logic [9:0]  alpha_fin;
   logic [7:0]  thr;
   logic        cmp_fail;
   logic [3:0]  tab_idx;

   // alpha * coverage / 8 with rounding, up to nine bits for coverage over eight
   assign scaled_full = 12'(pix.color_alpha) * 12'(pix.coverage_in) + 12'(fact_pkg::ROUND_HALF);
   assign scaled      = scaled_full[11:3];
   assign cov_scaled  = scaled[8:5];

   assign alpha_base = cfg.coverage_times_alpha ? scaled : {1'b0, pix.color_alpha};
   assign cov_base   = cfg.coverage_times_alpha ? cov_scaled : pix.coverage_in;
   assign aa_reject  = cfg.coverage_times_alpha & cfg.antialias_on & (cov_scaled == 4'd0);

   assign tab_idx = {pix.y_phase, pix.x_phase};
   assign mat_d   = cfg.rgb_dither_mode[0] ? fact_pkg::bayer_entry(tab_idx)
                                           : fact_pkg::magic_entry(tab_idx);

   always_comb begin
      case (cfg.alpha_dither_mode)
         fact_pkg::DITHER_MATRIX: dith = mat_d;
         fact_pkg::DITHER_INV:    dith = ~mat_d;
         fact_pkg::DITHER_NOISE:  dith = pix.pixel_noise[2:0];
         default:                 dith = 3'd0;
      endcase
   end

   assign alpha_dith = {1'b0, alpha_base} + 10'(dith);

   always_comb begin
      if (cfg.alpha_from_coverage) begin
         if (cfg.coverage_times_alpha) begin
            alpha_sel = {1'b0, alpha_base};
         end else begin
            alpha_sel = {1'b0, pix.coverage_in, 5'd0};
         end
         if (alpha_sel > 10'(fact_pkg::ALPHA_MAX)) begin
            alpha_sel = 10'(fact_pkg::ALPHA_MAX);
         end
      end else if (cfg.alpha_dither_mode != fact_pkg::DITHER_OFF) begin
         alpha_sel = alpha_dith;
         if (alpha_sel > 10'(fact_pkg::ALPHA_MAX)) begin
            alpha_sel = 10'(fact_pkg::ALPHA_MAX);
         end
      end else begin
         // may stay above 255 here; compare sees the full value
         alpha_sel = {1'b0, alpha_base};
      end
   end

   assign thr      = cfg.compare_uses_noise ? pix.pixel_noise : cfg.blend_alpha;
   assign cmp_fail = cfg.alpha_compare_on & (alpha_sel < 10'(thr));

   always_comb begin
      if (!pix.lane_active) begin
         alpha_fin        = 10'(pix.color_alpha);
         res.coverage_out = pix.coverage_in;
         res.accepted     = 1'b0;
      end else if (aa_reject) begin
         alpha_fin        = {1'b0, alpha_base};
         res.coverage_out = cov_base;
         res.accepted     = 1'b0;
      end else begin
         alpha_fin        = alpha_sel;
         res.coverage_out = cov_base;
         res.accepted     = ~cmp_fail;
      end
      if (alpha_fin > 10'(fact_pkg::ALPHA_MAX)) begin
         res.alpha_out = fact_pkg::ALPHA_MAX;
      end else begin
         res.alpha_out = alpha_fin[7:0];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fragment_alpha_coverage_test.sv
// ----------------------------------------------------------------------------
// fragment_alpha_coverage_test
// Per-pixel alpha/coverage stage of a fragment back end.
// ----------------------------------------------------------------------------
// One pixel word enters on req_chan, one result word leaves on rsp_chan.
// A pixel is taken when req_chan.valid and req_chan.ready are both high.
// The pixel is held in an input register; coverage scaling, alpha select or
// dither and the alpha compare run in one combinational pass into the result
// register, which drives rsp_chan.valid. Throughput is one pixel per cycle
// while rsp_chan.ready is high; both registers form a two-entry pipe,
// so a new pixel is taken while a finished result waits to be read.
// When rsp_chan.ready is low, the result register holds and the input
// register fills; req_chan.ready drops only when both are full.
// Configuration goes through the csr_ APB port, one register every 4 bytes;
// write it only while no pixel is in flight.
// Reset (synchronous, active high) empties the pipe and sets every
// configuration register to 0 except alpha dither mode, which resets to off.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_alpha_coverage_test (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   fact_chan_if.sink                                   req_chan,
   fact_chan_if.source                                 rsp_chan,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [fact_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [fact_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic      [fact_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                        csr_pready
);

   fact_pkg::fact_cfg_type    cfg;
   fact_pkg::fact_pixel_type  pix_ff;
   fact_pkg::fact_pixel_type  pix_in;
   fact_pkg::fact_result_type res_ff;
   fact_pkg::fact_result_type res_in;
   fact_pkg::fact_result_type calc_res;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_load;
   logic                      in_load;

   fact_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fact_calc u_calc (
      .cfg (cfg),
      .pix (pix_ff),
      .res (calc_res)
   );

   // result register frees up when empty or being read
   assign out_load       = ~out_valid_ff | rsp_chan.ready;
   assign in_load        = ~in_valid_ff | out_load;
   assign req_chan.ready = in_load;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = res_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      pix_in       = pix_ff;
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      if (in_load) begin
         in_valid_in = req_chan.valid;
         if (req_chan.valid) begin
            pix_in = req_chan.payload;
         end
      end
      if (out_load) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            res_in = calc_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      res_ff <= res_in;
   end

endmodule

`default_nettype wire
